// File: rtl/row_cache_lowest_index_replace_core_defines.svh
// Assertion macros shared by the row cache slot manager.
`ifndef ROW_CACHE_LOWEST_INDEX_REPLACE_CORE_DEFINES_SVH
`define ROW_CACHE_LOWEST_INDEX_REPLACE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RCLR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rclr: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RCLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rclr: next-cycle check failed");

`endif

// File: rtl/rclr_pkg.sv
package rclr_pkg;

    // Samples are grouped in rows of the status memory.
    localparam int ROW_W  = 32;
    localparam int ROW_BW = 5;

    localparam int CFG_SIZE_W  = 9;
    localparam int CFG_COUNT_W = 11;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_SIZE_W-1:0]  CFG_SIZE_RST  = 9'd256;
    localparam logic [CFG_COUNT_W-1:0] CFG_COUNT_RST = 11'd1024;

    typedef enum logic [0:0] {
        CFG_CACHE_SIZE   = 1'b0,
        CFG_SAMPLE_COUNT = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CMD_LOOKUP  = 2'd0,
        CMD_REPLACE = 2'd1,
        CMD_LOCK    = 2'd2,
        CMD_UNLOCK  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_NEVER   = 2'd0,
        ST_CACHED  = 2'd1,
        ST_EVICTED = 2'd2
    } t_status;

    // One row: eligibility and status of ROW_W consecutive samples.
    typedef struct packed {
        logic [ROW_W-1:0]    elig;
        t_status [ROW_W-1:0] status;
    } t_row;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_SEARCH,
        S_VREAD,
        S_VPICK,
        S_VSLOT,
        S_IDXW,
        S_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic read_idx;
        logic eval;
        logic search;
        logic read_vic;
        logic pick_vic;
        logic swap_vic;
        logic write_idx;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic go_search;
        logic found;
        logic last_chunk;
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/rclr_ifs.sv
interface rclr_req_if import rclr_pkg::*; #(
    parameter int IDX_W = 10
) ();
    logic             valid;
    logic             ready;
    t_cmd             cmd;
    logic [IDX_W-1:0] sample_index;

    modport source (output valid, cmd, sample_index, input ready);
    modport sink   (input valid, cmd, sample_index, output ready);
endinterface

interface rclr_rsp_if #(
    parameter int IDX_W  = 10,
    parameter int SLOT_W = 8
) ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              cache_full;
    logic [IDX_W-1:0]  victim_index;
    logic              error;

    modport source (output valid, hit, slot, cache_full, victim_index, error, input ready);
    modport sink   (input valid, hit, slot, cache_full, victim_index, error, output ready);
endinterface

// File: rtl/rclr_ctrl.sv
module rclr_ctrl import rclr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ:   n_state = S_EVAL;
            S_EVAL: begin
                n_state = i_sts.go_search ? S_SEARCH : S_FIN;
            end
            S_SEARCH: begin
                if (i_sts.found) begin
                    n_state = S_VREAD;
                end else if (i_sts.last_chunk) begin
                    n_state = S_FIN;
                end
            end
            S_VREAD:  n_state = S_VPICK;
            S_VPICK:  n_state = S_VSLOT;
            S_VSLOT:  n_state = S_IDXW;
            S_IDXW:   n_state = S_FIN;
            S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // hold off words while reset is applied
                o_in_ready   = i_rst_n;
                o_cmd.accept = i_in_valid && i_rst_n;
            end
            S_READ:   o_cmd.read_idx  = 1'b1;
            S_EVAL:   o_cmd.eval      = 1'b1;
            S_SEARCH: o_cmd.search    = 1'b1;
            S_VREAD:  o_cmd.read_vic  = 1'b1;
            S_VPICK:  o_cmd.pick_vic  = 1'b1;
            S_VSLOT:  o_cmd.swap_vic  = 1'b1;
            S_IDXW:   o_cmd.write_idx = 1'b1;
            S_FIN:    o_cmd.load_out  = i_sts.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

// File: rtl/rclr_datapath.sv
module rclr_datapath import rclr_pkg::*; #(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_SLOTS   = 256,
    localparam int IDX_W      = $clog2(MAX_SAMPLES),
    localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_reg              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  t_cmd                  i_req_cmd,
    input  logic [IDX_W-1:0]      i_req_idx,
    input  logic                  i_rsp_ready,
    output logic                  o_rsp_valid,
    output logic                  o_hit,
    output logic [SLOT_W-1:0]     o_slot,
    output logic                  o_full,
    output logic [IDX_W-1:0]      o_victim,
    output logic                  o_error
);

    localparam int OCC_W      = $clog2(MAX_SLOTS + 1);
    localparam int NUM_ROWS   = (MAX_SAMPLES + ROW_W - 1) / ROW_W;
    localparam int ROW_AW     = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int SIDX_W     = ROW_AW + ROW_BW;
    localparam int NUM_CHUNKS = (NUM_ROWS + ROW_W - 1) / ROW_W;
    localparam int CH_W       = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int SZ_W       = (OCC_W > CFG_SIZE_W) ? OCC_W : CFG_SIZE_W;
    localparam int CNT_W      = (IDX_W + 1 > CFG_COUNT_W) ? IDX_W + 1 : CFG_COUNT_W;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              full;
        logic [IDX_W-1:0]  victim;
        logic              error;
    } t_res;

    // Lowest set bit: {found, position}.
    function automatic logic [ROW_BW:0] find_lowest(input logic [ROW_W-1:0] v);
        logic [ROW_BW:0] res;
        res = '0;
        for (int k = ROW_W - 1; k >= 0; k--) begin
            if (v[k]) begin
                res = {1'b1, ROW_BW'(k)};
            end
        end
        return res;
    endfunction

    logic [CFG_SIZE_W-1:0]  r_cache_size;
    logic [CFG_COUNT_W-1:0] r_sample_count;

    t_cmd              r_cmd;
    logic [IDX_W-1:0]  r_idx;
    logic              r_bad;

    t_row              r_row_mem [NUM_ROWS];
    t_row              r_row_q;
    logic              r_touch_q;
    logic [SLOT_W-1:0] r_slot_mem [MAX_SAMPLES];
    logic [SLOT_W-1:0] r_slot_q;

    logic [NUM_ROWS-1:0] r_live;
    logic [NUM_ROWS-1:0] r_touched;
    logic [OCC_W-1:0]    r_occ;

    t_row              r_idx_row;
    logic [CH_W-1:0]   r_chunk;
    logic [ROW_AW-1:0] r_vrow;
    logic [ROW_BW-1:0] r_vbit;
    t_row              r_vic_row;

    t_res r_pend;
    t_res r_out;
    logic r_out_valid;

    logic [CNT_W-1:0]  eff_count;
    logic [SZ_W-1:0]   eff_size;
    logic              in_bad;
    logic              can_alloc;
    logic [SIDX_W-1:0] idx_ext;
    logic [ROW_AW-1:0] idx_row_a;
    logic [ROW_BW-1:0] idx_bit;
    t_row              row_rd;
    t_status           cur_st;
    logic              cur_el;
    logic              cached;

    logic [NUM_CHUNKS*ROW_W-1:0] live_pad;
    logic [ROW_W-1:0]            chunk_bits;
    logic [ROW_BW:0]             chunk_find;
    logic [ROW_BW:0]             vic_find;
    t_row                        vic_row_new;
    logic [IDX_W-1:0]            vic_idx;
    t_row                        idx_base;
    t_row                        idx_row_new;

    t_res ev_res;
    t_row ev_row;
    logic ev_wr;
    logic ev_alloc;

    logic              row_we;
    logic [ROW_AW-1:0] row_wa;
    t_row              row_wd;
    logic              row_re;
    logic [ROW_AW-1:0] row_ra;
    logic              slot_we;
    logic [IDX_W-1:0]  slot_wa;
    logic [SLOT_W-1:0] slot_wd;
    logic              slot_re;
    logic [IDX_W-1:0]  slot_ra;

    assign eff_count = (CNT_W'(r_sample_count) > CNT_W'(MAX_SAMPLES)) ?
                       CNT_W'(MAX_SAMPLES) : CNT_W'(r_sample_count);
    assign eff_size  = (SZ_W'(r_cache_size) > SZ_W'(MAX_SLOTS)) ?
                       SZ_W'(MAX_SLOTS) : SZ_W'(r_cache_size);
    assign in_bad    = CNT_W'(i_req_idx) >= eff_count;
    assign can_alloc = SZ_W'(r_occ) < eff_size;

    assign idx_ext   = SIDX_W'(r_idx);
    assign idx_row_a = idx_ext[SIDX_W-1:ROW_BW];
    assign idx_bit   = idx_ext[ROW_BW-1:0];

    // A row never written reads as all never cached, none eligible.
    assign row_rd = r_touch_q ? r_row_q : '0;
    assign cur_st = row_rd.status[idx_bit];
    assign cur_el = row_rd.elig[idx_bit];
    assign cached = (cur_st == ST_CACHED);

    assign live_pad   = (NUM_CHUNKS*ROW_W)'(r_live);
    assign chunk_bits = live_pad[r_chunk*ROW_W +: ROW_W];
    assign chunk_find = find_lowest(chunk_bits);
    assign vic_find   = find_lowest(row_rd.elig);
    assign vic_idx    = IDX_W'({r_vrow, r_vbit});

    always_comb begin
        vic_row_new = row_rd;
        vic_row_new.status[vic_find[ROW_BW-1:0]] = ST_EVICTED;
        vic_row_new.elig[vic_find[ROW_BW-1:0]]   = 1'b0;
    end

    // Victim and requester may share a row: build on the updated copy.
    always_comb begin
        idx_base    = (idx_row_a == r_vrow) ? r_vic_row : r_idx_row;
        idx_row_new = idx_base;
        idx_row_new.status[idx_bit] = ST_CACHED;
        idx_row_new.elig[idx_bit]   = 1'b1;
    end

    always_comb begin
        ev_res   = '0;
        ev_row   = row_rd;
        ev_wr    = 1'b0;
        ev_alloc = 1'b0;
        if (r_bad) begin
            ev_res.error = 1'b1;
        end else begin
            case (r_cmd)
                CMD_LOOKUP: begin
                    if (cached) begin
                        ev_res.hit  = 1'b1;
                        ev_res.slot = r_slot_q;
                    end else if (can_alloc) begin
                        ev_row.status[idx_bit] = ST_CACHED;
                        ev_row.elig[idx_bit]   = 1'b1;
                        ev_wr       = 1'b1;
                        ev_alloc    = 1'b1;
                        ev_res.slot = r_occ[SLOT_W-1:0];
                    end else begin
                        ev_res.full = 1'b1;
                    end
                end
                CMD_REPLACE: begin
                    ev_res.error = cached;
                end
                CMD_LOCK: begin
                    if (cur_el) begin
                        ev_row.elig[idx_bit] = 1'b0;
                        ev_wr = 1'b1;
                    end else begin
                        ev_res.error = 1'b1;
                    end
                end
                CMD_UNLOCK: begin
                    if (cached && !cur_el) begin
                        ev_row.elig[idx_bit] = 1'b1;
                        ev_wr = 1'b1;
                    end else begin
                        ev_res.error = 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb begin
        row_we = 1'b0;
        row_wa = idx_row_a;
        row_wd = ev_row;
        if (i_cmd.eval && ev_wr) begin
            row_we = 1'b1;
        end else if (i_cmd.swap_vic) begin
            row_we = 1'b1;
            row_wa = r_vrow;
            row_wd = r_vic_row;
        end else if (i_cmd.write_idx) begin
            row_we = 1'b1;
            row_wd = idx_row_new;
        end
    end

    assign row_re  = i_cmd.read_idx || i_cmd.read_vic;
    assign row_ra  = i_cmd.read_vic ? r_vrow : idx_row_a;
    assign slot_we = (i_cmd.eval && ev_alloc) || i_cmd.swap_vic;
    assign slot_wa = r_idx;
    assign slot_wd = i_cmd.swap_vic ? r_slot_q : r_occ[SLOT_W-1:0];
    assign slot_re = i_cmd.read_idx || i_cmd.pick_vic;
    assign slot_ra = i_cmd.pick_vic ? IDX_W'({r_vrow, vic_find[ROW_BW-1:0]}) : r_idx;

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            r_row_mem[row_wa] <= row_wd;
        end
        if (row_re) begin
            r_row_q <= r_row_mem[row_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_wa] <= slot_wd;
        end
        if (slot_re) begin
            r_slot_q <= r_slot_mem[slot_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_size   <= CFG_SIZE_RST;
            r_sample_count <= CFG_COUNT_RST;
            r_live         <= '0;
            r_touched      <= '0;
            r_occ          <= '0;
            r_out_valid    <= 1'b0;
            r_touch_q      <= 1'b0;
            r_chunk        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CACHE_SIZE:   r_cache_size   <= i_cfg_data[CFG_SIZE_W-1:0];
                    CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[CFG_COUNT_W-1:0];
                    default:          r_cache_size   <= r_cache_size;
                endcase
            end
            if (row_re) begin
                r_touch_q <= r_touched[row_ra];
            end
            if (row_we) begin
                r_touched[row_wa] <= 1'b1;
                r_live[row_wa]    <= |row_wd.elig;
            end
            if (i_cmd.eval && ev_alloc) begin
                r_occ <= r_occ + OCC_W'(1);
            end
            if (i_cmd.eval) begin
                r_chunk <= '0;
            end else if (i_cmd.search && !chunk_find[ROW_BW]) begin
                r_chunk <= r_chunk + CH_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd <= i_req_cmd;
            r_idx <= i_req_idx;
            r_bad <= in_bad;
        end
        if (i_cmd.eval) begin
            r_pend    <= ev_res;
            r_idx_row <= row_rd;
        end
        if (i_cmd.search) begin
            if (chunk_find[ROW_BW]) begin
                r_vrow <= ROW_AW'({r_chunk, chunk_find[ROW_BW-1:0]});
            end else begin
                r_pend <= '{error: 1'b1, default: '0};
            end
        end
        if (i_cmd.pick_vic) begin
            r_vbit    <= vic_find[ROW_BW-1:0];
            r_vic_row <= vic_row_new;
        end
        if (i_cmd.swap_vic) begin
            r_pend <= '{slot: r_slot_q, victim: vic_idx, default: '0};
        end
        if (i_cmd.load_out) begin
            r_out <= r_pend;
        end
    end

    assign o_sts.go_search  = !r_bad && (r_cmd == CMD_REPLACE) && !cached;
    assign o_sts.found      = chunk_find[ROW_BW];
    assign o_sts.last_chunk = (r_chunk == CH_W'(NUM_CHUNKS - 1));
    assign o_sts.out_free   = !r_out_valid || i_rsp_ready;

    assign o_rsp_valid = r_out_valid;
    assign o_hit       = r_out.hit;
    assign o_slot      = r_out.slot;
    assign o_full      = r_out.full;
    assign o_victim    = r_out.victim;
    assign o_error     = r_out.error;

endmodule

// File: rtl/row_cache_lowest_index_replace_core.sv
// Slot manager for a cache of kernel rows keyed by sample index. Each request word
// (lookup, replace, lock, unlock) yields one result word. Lookup, lock, unlock and a
// rejected request read the status row, evaluate it and then load the result register.
// A replace that passes evaluation scans the eligibility summary in 32-row groups for
// the lowest eligible sample. If it finds one, it reads the victim's row, picks the
// victim and reads its slot, writes the victim's row and the requester's slot, and
// writes the requester's row before loading the result; else it loads an error result.
// The steps are set by the status row memory, which each request reads and writes in
// turn, and by the victim slot read. A new word is accepted while the previous result
// waits; a held result stalls only the end of the following request. Status rows carry
// a written flag per 32 samples, so the block needs no clearing pass and takes requests
// right after reset. Write the config registers only while no word is in flight.
`include "row_cache_lowest_index_replace_core_defines.svh"

module row_cache_lowest_index_replace_core import rclr_pkg::*; #(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_SLOTS   = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_reg              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rclr_req_if.sink              i_req,
    rclr_rsp_if.source            o_rsp
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;

    rclr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (dp_sts),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd)
    );

    rclr_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_SLOTS   (MAX_SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_req_cmd   (i_req.cmd),
        .i_req_idx   (i_req.sample_index),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_hit       (o_rsp.hit),
        .o_slot      (o_rsp.slot),
        .o_full      (o_rsp.cache_full),
        .o_victim    (o_rsp.victim_index),
        .o_error     (o_rsp.error)
    );

    assign i_req.ready = in_ready;

    // An accepted word always starts with the status row read.
    `RCLR_ASSERT_NEXT(a_accept_reads, i_clk, i_rst_n, i_req.valid && i_req.ready, dp_cmd.read_idx)

    // Never overwrite a result that is still waiting.
    `RCLR_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, dp_cmd.load_out, !o_rsp.valid || o_rsp.ready)

    // A rejected request carries nothing else.
    `RCLR_ASSERT_NOW(a_error_clean, i_clk, i_rst_n, o_rsp.valid && o_rsp.error, !o_rsp.hit && !o_rsp.cache_full && o_rsp.slot == '0 && o_rsp.victim_index == '0)

    // Hit and full exclude each other and name no victim.
    `RCLR_ASSERT_NOW(a_hit_full_excl, i_clk, i_rst_n, o_rsp.valid && (o_rsp.hit || o_rsp.cache_full), !(o_rsp.hit && o_rsp.cache_full) && o_rsp.victim_index == '0)

endmodule
